[hw/rtl/rcpr_pkg.sv]
// Shared types and constants for the remote-control packet receiver.
package rcpr_pkg;

    localparam int ChannelBits = 16;
    localparam logic [15:0] ChanMask = 16'((32'd1 << ChannelBits) - 32'd1);

    localparam logic [7:0] CheckValue = 8'ha5;
    localparam int         AnalogBit  = 0;
    localparam logic [7:0] ModeFlight = 8'd0;
    localparam logic [7:0] ModeCal    = 8'd2;
    localparam logic [7:0] CountMax   = 8'hff;

    localparam logic FuncPacket = 1'b0;
    localparam logic FuncTick   = 1'b1;

    localparam logic [1:0] RegStickHigh   = 2'd0;
    localparam logic [1:0] RegStickLow    = 2'd1;
    localparam logic [1:0] RegDisarmTicks = 2'd2;
    localparam logic [1:0] RegArmTicks    = 2'd3;

    localparam int InDataBits  = 96;
    localparam int OutDataBits = 80;

    typedef struct packed {
        logic [15:0] stick_high;
        logic [15:0] stick_low;
        logic [7:0]  disarm_ticks;
        logic [7:0]  arm_ticks;
    } cfg_t;

    // The first field sits in the highest bits and the last field in the lowest bits.
    typedef struct packed {
        logic [7:0]  check_byte;
        logic [7:0]  packet_id;
        logic [15:0] roll_in;
        logic [15:0] pitch_in;
        logic [15:0] yaw_in;
        logic [15:0] throttle_in;
        logic [7:0]  mode_byte;
        logic [7:0]  trigger_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  last_id;
        logic [15:0] roll_out;
        logic [15:0] pitch_out;
        logic [15:0] yaw_out;
        logic [15:0] throttle_out;
        logic        gyro_cal_request;
        logic        flight_mode_set;
        logic        armed;
        logic        packet_accepted;
    } result_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] c);
        sat_inc = (c == CountMax) ? CountMax : c + 8'd1;
    endfunction

endpackage

[hw/rtl/rcpr_cfg.sv]
// Configuration register bank for the packet receiver.
module rcpr_cfg
    import rcpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_high   <= 16'd1800;
            cfg_reg.stick_low    <= 16'd1200;
            cfg_reg.disarm_ticks <= 8'd10;
            cfg_reg.arm_ticks    <= 8'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegStickHigh:   cfg_reg.stick_high   <= cfg_wdata;
                RegStickLow:    cfg_reg.stick_low    <= cfg_wdata;
                RegDisarmTicks: cfg_reg.disarm_ticks <= cfg_wdata[7:0];
                RegArmTicks:    cfg_reg.arm_ticks    <= cfg_wdata[7:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/rcpr_state.sv]
// Receiver and arming state with its single-pass next-state logic.
module rcpr_state
    import rcpr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  logic    func,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [15:0] throttle_reg, yaw_reg, pitch_reg, roll_reg;
    logic [15:0] throttle_next, yaw_next, pitch_next, roll_next;
    logic [7:0]  prev_mode_reg, prev_mode_next;
    logic [7:0]  latest_id_reg, latest_id_next;
    logic        mode_flag_reg, mode_flag_next;
    logic        arm_state_reg, arm_state_next;
    logic [7:0]  disarm_count_reg, disarm_count_next;
    logic [7:0]  arm_count_reg, arm_count_next;

    logic accepted, cal;
    logic common, disarm_hold, arm_hold, arm_mid;
    logic [7:0] dc_inc, ac_inc;

    always_comb
    begin
        throttle_next     = throttle_reg;
        yaw_next          = yaw_reg;
        pitch_next        = pitch_reg;
        roll_next         = roll_reg;
        prev_mode_next    = prev_mode_reg;
        latest_id_next    = latest_id_reg;
        mode_flag_next    = mode_flag_reg;
        arm_state_next    = arm_state_reg;
        disarm_count_next = disarm_count_reg;
        arm_count_next    = arm_count_reg;
        accepted          = 1'b0;
        cal               = 1'b0;

        common = (pitch_reg <= cfg.stick_low) && (throttle_reg <= cfg.stick_low);
        disarm_hold = arm_state_reg && common && (roll_reg >= cfg.stick_high)
                      && (yaw_reg <= cfg.stick_low);
        dc_inc = sat_inc(disarm_count_reg);
        ac_inc = sat_inc(arm_count_reg);
        arm_mid = arm_state_reg;
        arm_hold = 1'b0;

        if (func == FuncPacket)
        begin
            if (item.check_byte == CheckValue)
            begin
                accepted = 1'b1;
                if (item.trigger_byte[AnalogBit])
                begin
                    if (item.mode_byte == ModeFlight)
                        mode_flag_next = 1'b1;
                    cal = (item.mode_byte == ModeCal) && (prev_mode_reg != ModeCal);
                    throttle_next  = item.throttle_in & ChanMask;
                    yaw_next       = item.yaw_in & ChanMask;
                    pitch_next     = item.pitch_in & ChanMask;
                    roll_next      = item.roll_in & ChanMask;
                    prev_mode_next = item.mode_byte;
                end
                latest_id_next = item.packet_id;
            end
        end
        else
        begin
            // Disarm rule first, then the arm rule sees the state it left.
            disarm_count_next = disarm_hold ? dc_inc : 8'd0;
            if ((disarm_count_next > cfg.disarm_ticks) && arm_state_reg)
            begin
                arm_mid           = 1'b0;
                disarm_count_next = 8'd0;
            end
            arm_hold = !arm_mid && common && (yaw_reg >= cfg.stick_high)
                       && (roll_reg <= cfg.stick_low);
            arm_count_next = arm_hold ? ac_inc : 8'd0;
            arm_state_next = arm_mid;
            if ((arm_count_next >= cfg.arm_ticks) && !arm_mid)
            begin
                arm_state_next = 1'b1;
                arm_count_next = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            throttle_reg     <= '0;
            yaw_reg          <= '0;
            pitch_reg        <= '0;
            roll_reg         <= '0;
            prev_mode_reg    <= '0;
            latest_id_reg    <= '0;
            mode_flag_reg    <= 1'b0;
            arm_state_reg    <= 1'b0;
            disarm_count_reg <= '0;
            arm_count_reg    <= '0;
        end
        else if (advance)
        begin
            throttle_reg     <= throttle_next;
            yaw_reg          <= yaw_next;
            pitch_reg        <= pitch_next;
            roll_reg         <= roll_next;
            prev_mode_reg    <= prev_mode_next;
            latest_id_reg    <= latest_id_next;
            mode_flag_reg    <= mode_flag_next;
            arm_state_reg    <= arm_state_next;
            disarm_count_reg <= disarm_count_next;
            arm_count_reg    <= arm_count_next;
        end
    end

    always_comb
    begin
        result.packet_accepted  = accepted;
        result.armed            = arm_state_next;
        result.flight_mode_set  = mode_flag_next;
        result.gyro_cal_request = cal;
        result.throttle_out     = throttle_next;
        result.yaw_out          = yaw_next;
        result.pitch_out        = pitch_next;
        result.roll_out         = roll_next;
        result.last_id          = latest_id_next;
    end

endmodule

[hw/rtl/rc_packet_receiver_with_arming.sv]
// Top level: input register, receiver state logic and result register.
//
// Each item is a received packet or a gesture tick and gives exactly one
// result item. An item is registered on entry, evaluated in one pass against
// the held channel and arming state, and the result is registered at the
// output; one item per clock is sustained while the output is taken, and the
// result is offered once its item has passed both registers. Configuration
// registers reset to stick high 1800, stick low 1200 and both tick counts 10.
module rc_packet_receiver_with_arming
    import rcpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // trigger_byte, mode_byte, throttle_in, yaw_in, pitch_in, roll_in,
    // packet_id, check_byte
    input  logic [InDataBits-1:0]  s_tdata,
    // func
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // packet_accepted, armed, flight_mode_set, gyro_cal_request, throttle_out,
    // yaw_out, pitch_out, roll_out, last_id, 4 zero bits
    output logic [OutDataBits-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_wdata
);

    localparam int ResultBits = $bits(result_t);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    in_func_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    advance;
    cfg_t    cfg;
    result_t result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    rcpr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rcpr_state u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .func    (in_func_reg),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= item_t'(s_tdata);
            in_func_reg <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Hold the result until taken.
    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataBits - ResultBits){1'b0}}, out_data_reg};

endmodule

[verif/rc_packet_receiver_with_arming_test.sv]
// Self-checking testbench for the remote-control packet receiver with stick arming.
module rc_packet_receiver_with_arming_test;
    import rcpr_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [InDataBits-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OutDataBits-1:0] m_tdata;
    logic                   cfg_we;
    logic [1:0]             cfg_index;
    logic [15:0]            cfg_wdata;

    rc_packet_receiver_with_arming uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Tracks the receiver state and holds the status items still owed by the block.
    class rc_state_tracker;
        cfg_t        cfg;
        logic [15:0] thr;
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [15:0] roll;
        logic [7:0]  prev_mode;
        logic [7:0]  last_id;
        logic [7:0]  disarm_cnt;
        logic [7:0]  arm_cnt;
        logic        mode_flag;
        logic        armed;
        result_t     pending[$];
        int unsigned failures;

        function new();
            cfg.stick_high   = 16'd1800;
            cfg.stick_low    = 16'd1200;
            cfg.disarm_ticks = 8'd10;
            cfg.arm_ticks    = 8'd10;
            thr        = '0;
            yaw        = '0;
            pitch      = '0;
            roll       = '0;
            prev_mode  = '0;
            last_id    = '0;
            disarm_cnt = '0;
            arm_cnt    = '0;
            mode_flag  = 1'b0;
            armed      = 1'b0;
            failures   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                RegStickHigh:   cfg.stick_high   = val;
                RegStickLow:    cfg.stick_low    = val;
                RegDisarmTicks: cfg.disarm_ticks = val[7:0];
                RegArmTicks:    cfg.arm_ticks    = val[7:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] bump(logic [7:0] c);
            return (c == CountMax) ? c : c + 8'd1;
        endfunction

        function void take_item(logic func, item_t it);
            result_t r;
            logic    common;
            r = '0;
            if (func == FuncPacket) begin
                if (it.check_byte == CheckValue) begin
                    r.packet_accepted = 1'b1;
                    if (it.trigger_byte[AnalogBit]) begin
                        if (it.mode_byte == ModeFlight)
                            mode_flag = 1'b1;
                        if (it.mode_byte == ModeCal && prev_mode != ModeCal)
                            r.gyro_cal_request = 1'b1;
                        thr       = it.throttle_in & ChanMask;
                        yaw       = it.yaw_in & ChanMask;
                        pitch     = it.pitch_in & ChanMask;
                        roll      = it.roll_in & ChanMask;
                        prev_mode = it.mode_byte;
                    end
                    last_id = it.packet_id;
                end
            end
            else begin
                common = (pitch <= cfg.stick_low) && (thr <= cfg.stick_low);
                // disarm rule first, then arm rule on the state it leaves
                if (armed && common && roll >= cfg.stick_high && yaw <= cfg.stick_low)
                    disarm_cnt = bump(disarm_cnt);
                else
                    disarm_cnt = '0;
                if (disarm_cnt > cfg.disarm_ticks && armed) begin
                    armed      = 1'b0;
                    disarm_cnt = '0;
                end
                if (!armed && common && yaw >= cfg.stick_high && roll <= cfg.stick_low)
                    arm_cnt = bump(arm_cnt);
                else
                    arm_cnt = '0;
                if (arm_cnt >= cfg.arm_ticks && !armed) begin
                    armed   = 1'b1;
                    arm_cnt = '0;
                end
            end
            r.armed           = armed;
            r.flight_mode_set = mode_flag;
            r.throttle_out    = thr;
            r.yaw_out         = yaw;
            r.pitch_out       = pitch;
            r.roll_out        = roll;
            r.last_id         = last_id;
            pending.push_back(r);
        endfunction

        function void flag(string what, logic [15:0] exp, logic [15:0] got);
            failures++;
            if (failures <= 10)
                $display("mismatch in %s: expected %h, got %h", what, exp, got);
        endfunction

        function void check_report(result_t got);
            result_t exp;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("status item with none expected: %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got.packet_accepted !== exp.packet_accepted)
                flag("packet_accepted", exp.packet_accepted, got.packet_accepted);
            if (got.armed !== exp.armed)
                flag("armed", exp.armed, got.armed);
            if (got.flight_mode_set !== exp.flight_mode_set)
                flag("flight_mode_set", exp.flight_mode_set, got.flight_mode_set);
            if (got.gyro_cal_request !== exp.gyro_cal_request)
                flag("gyro_cal_request", exp.gyro_cal_request, got.gyro_cal_request);
            if (got.throttle_out !== exp.throttle_out)
                flag("throttle_out", exp.throttle_out, got.throttle_out);
            if (got.yaw_out !== exp.yaw_out)
                flag("yaw_out", exp.yaw_out, got.yaw_out);
            if (got.pitch_out !== exp.pitch_out)
                flag("pitch_out", exp.pitch_out, got.pitch_out);
            if (got.roll_out !== exp.roll_out)
                flag("roll_out", exp.roll_out, got.roll_out);
            if (got.last_id !== exp.last_id)
                flag("last_id", exp.last_id, got.last_id);
        endfunction
    endclass

    rc_state_tracker tracker = new();

    bit tx_gaps;
    bit rx_gaps;
    bit hold_req;
    int sent;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls, plus a long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                m_tready   = 1'b0;
                stall_left = 80;
            end
            else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end
            else begin
                m_tready = 1'b1;
                if (rx_gaps && $urandom_range(0, 99) < 25)
                    stall_left = gap_len();
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                tracker.check_report(result_t'(m_tdata[$bits(result_t)-1:0]));
        end
    end

    function automatic item_t random_item();
        item_t it;
        it = {$urandom, $urandom, $urandom};
        return it;
    endfunction

    function automatic item_t make_packet(logic [7:0] trig, logic [7:0] mode,
                                          logic [15:0] thr, logic [15:0] yaw,
                                          logic [15:0] pitch, logic [15:0] roll,
                                          logic [7:0] id, logic [7:0] chk);
        item_t it;
        it.trigger_byte = trig;
        it.mode_byte    = mode;
        it.throttle_in  = thr;
        it.yaw_in       = yaw;
        it.pitch_in     = pitch;
        it.roll_in      = roll;
        it.packet_id    = id;
        it.check_byte   = chk;
        return it;
    endfunction

    function automatic logic [15:0] high_val();
        case ($urandom_range(0, 3))
            0:       return tracker.cfg.stick_high;
            1:       return 16'hffff;
            default: return 16'($urandom_range(65535, tracker.cfg.stick_high));
        endcase
    endfunction

    function automatic logic [15:0] low_val();
        case ($urandom_range(0, 3))
            0:       return tracker.cfg.stick_low;
            1:       return 16'h0000;
            default: return 16'($urandom_range(tracker.cfg.stick_low, 0));
        endcase
    endfunction

    // Values on and either side of the thresholds.
    function automatic logic [15:0] edge_val();
        case ($urandom_range(0, 6))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return tracker.cfg.stick_high;
            3:       return tracker.cfg.stick_high - 16'd1;
            4:       return tracker.cfg.stick_low;
            5:       return tracker.cfg.stick_low + 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_item(input logic func, input item_t it);
        int idle;
        idle = tx_gaps ? gap_len() : 0;
        if (idle > 0) begin
            s_tvalid = 1'b0;
            repeat (idle) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = it;
        do @(posedge clk); while (!s_tready);
        tracker.take_item(func, it);
        sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (tracker.pending.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        tracker.set_reg(idx, val);
    endtask

    task automatic set_thresholds(input logic [15:0] hi, input logic [15:0] lo,
                                  input logic [15:0] dis, input logic [15:0] arm);
        wait_drained();
        write_reg(RegStickHigh, hi);
        write_reg(RegStickLow, lo);
        write_reg(RegDisarmTicks, dis);
        write_reg(RegArmTicks, arm);
    endtask

    // Latch a stick gesture, then tick around the threshold that it aims at.
    task automatic gesture(input bit to_arm);
        item_t it;
        int    goal;
        int    n;
        it = random_item();
        it.check_byte              = CheckValue;
        it.trigger_byte[AnalogBit] = 1'b1;
        it.pitch_in    = low_val();
        it.throttle_in = low_val();
        if (to_arm) begin
            it.yaw_in  = high_val();
            it.roll_in = low_val();
            goal = int'(tracker.cfg.arm_ticks);
        end
        else begin
            it.roll_in = high_val();
            it.yaw_in  = low_val();
            goal = int'(tracker.cfg.disarm_ticks) + 1;
        end
        if ($urandom_range(0, 9) == 0)
            it.yaw_in = 16'($urandom);
        push_item(FuncPacket, it);
        n = $urandom_range(0, 1) ? goal + $urandom_range(0, 2) : $urandom_range(0, goal);
        repeat (n)
        begin
            if ($urandom_range(0, 19) == 0)
                push_item(FuncPacket, random_item());
            push_item(FuncTick, random_item());
        end
    endtask

    task automatic run_random(input int budget);
        int    target;
        int    r;
        item_t it;
        target = sent + budget;
        while (sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                gesture(1'b1);
            else if (r < 55)
                gesture(1'b0);
            else if (r < 70) begin
                it = random_item();
                it.check_byte              = CheckValue;
                it.trigger_byte[AnalogBit] = 1'b1;
                case ($urandom_range(0, 3))
                    0:       it.mode_byte = ModeFlight;
                    1, 2:    it.mode_byte = ModeCal;
                    default: ;
                endcase
                it.throttle_in = edge_val();
                it.yaw_in      = edge_val();
                it.pitch_in    = edge_val();
                it.roll_in     = edge_val();
                push_item(FuncPacket, it);
            end
            else if (r < 85) begin
                it = random_item();
                if ($urandom_range(0, 1))
                    it.check_byte = CheckValue;
                push_item(FuncPacket, it);
            end
            else
                push_item(1'($urandom_range(0, 1)), random_item());
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FuncPacket;
        cfg_we    = 1'b0;
        cfg_index = RegStickHigh;
        cfg_wdata = '0;
        tx_gaps   = 1'b1;
        rx_gaps   = 1'b1;
        hold_req  = 1'b0;
        sent      = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // tick from reset, rejected packets, then id-only and analog packets
        push_item(FuncTick, random_item());
        push_item(FuncPacket, make_packet(8'h01, 8'h00, 16'hffff, 16'hffff, 16'hffff,
                                          16'hffff, 8'h11, 8'h00));
        push_item(FuncPacket, make_packet(8'hff, 8'h00, 16'd5, 16'd5, 16'd5, 16'd5,
                                          8'h12, 8'ha4));
        push_item(FuncPacket, make_packet(8'h01, 8'h02, 16'd5, 16'd5, 16'd5, 16'd5,
                                          8'h13, 8'hff));
        push_item(FuncPacket, make_packet(8'hfe, 8'h00, 16'hffff, 16'hffff, 16'hffff,
                                          16'hffff, 8'hff, CheckValue));
        push_item(FuncPacket, make_packet(8'hff, ModeFlight, 16'hffff, 16'hffff, 16'hffff,
                                          16'hffff, 8'h00, CheckValue));
        push_item(FuncPacket, make_packet(8'h01, ModeCal, 16'h0000, 16'h0000, 16'h0000,
                                          16'h0000, 8'h21, CheckValue));
        push_item(FuncPacket, make_packet(8'h01, ModeCal, 16'h1234, 16'h5678, 16'h9abc,
                                          16'hdef0, 8'h22, CheckValue));
        // not analog: mode is ignored, so the next cal packet still sees mode 2
        push_item(FuncPacket, make_packet(8'h00, 8'h05, 16'h1111, 16'h2222, 16'h3333,
                                          16'h4444, 8'h23, CheckValue));
        push_item(FuncPacket, make_packet(8'h03, ModeCal, 16'h0001, 16'h0002, 16'h0003,
                                          16'h0004, 8'h24, CheckValue));
        push_item(FuncPacket, make_packet(8'h01, 8'hff, 16'h0000, 16'h0000, 16'h0000,
                                          16'h0000, 8'h25, CheckValue));
        push_item(FuncPacket, make_packet(8'h81, ModeCal, 16'h0000, 16'h0000, 16'h0000,
                                          16'h0000, 8'h26, CheckValue));
        // arm gesture on the exact thresholds, held for the arm count
        push_item(FuncPacket, make_packet(8'h01, 8'h01, 16'd1200, 16'd1800, 16'd0,
                                          16'd1200, 8'h27, CheckValue));
        repeat (10) push_item(FuncTick, random_item());

        run_random(75);
        wait_drained();
        run_random(75);

        set_thresholds(16'hffff, 16'h0000, 16'd0, 16'd1);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_random(100);

        set_thresholds(16'h0000, 16'hffff, 16'd5, 16'd3);
        tx_gaps = 1'b1;
        run_random(80);

        // counters run into saturation here
        set_thresholds(16'd1800, 16'd1200, 16'd254, 16'd255);
        tx_gaps = 1'b0;
        rx_gaps = 1'b1;
        gesture(1'b1);
        gesture(1'b0);
        run_random(150);

        set_thresholds(16'($urandom_range(40000, 1000)), 16'($urandom_range(30000, 0)),
                       {8'($urandom), 8'($urandom_range(20, 0))},
                       {8'($urandom), 8'($urandom_range(20, 1))});
        hold_req = 1'b1;
        run_random(20);
        tx_gaps = 1'b1;
        run_random(80);

        wait_drained();
        repeat (6) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/rcpr_pkg.sv
hw/rtl/rcpr_cfg.sv
hw/rtl/rcpr_state.sv
hw/rtl/rc_packet_receiver_with_arming.sv
verif/rc_packet_receiver_with_arming_test.sv
